### rtl/core/vals_pkg.sv
// Shared types and constants of the voice allocator.
`default_nettype none

package vals_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] ACT_PLAY   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  // Field widths fixed by the stream format
  localparam int unsigned SOUND_W  = 10;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned VOICE_W  = 3;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned PITCH_W  = 8;
  localparam int unsigned IN_DW    = 48;
  localparam int unsigned OUT_DW   = 24;

  // Percent limits
  localparam logic signed [LEVEL_W-1:0] VOL_MIN   = 16'sd0;
  localparam logic signed [LEVEL_W-1:0] VOL_MAX   = 16'sd100;
  localparam logic signed [LEVEL_W-1:0] PITCH_MIN = 16'sd50;
  localparam logic signed [LEVEL_W-1:0] PITCH_MAX = 16'sd150;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd6;

  // Update commands from the sequencer to the voice store
  typedef struct packed {
    logic identity;  // restore identity priority order
    logic stop_all;  // clear every playing flag
    logic finish;    // clear one playing flag
    logic commit;    // move the selected position to the back and attach sound
  } store_cmd_t;

  // What the probe reports about the voice at the probed position
  typedef struct packed {
    logic playing;
    logic match;     // voice holds the requested sound
  } probe_t;

endpackage

`default_nettype wire

### rtl/core/vals_store.sv
// Voice store: priority order, attached sounds and flags, with one probe port.
`default_nettype none

module vals_store #(
  parameter int unsigned MAX_VOICES = 8,
  parameter int unsigned SND_W      = 10,
  parameter int unsigned VW         = $clog2(MAX_VOICES),
  parameter int unsigned CW         = $clog2(MAX_VOICES + 1)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  vals_pkg::store_cmd_t    cmd_i,
  input  wire  [VW-1:0]           fin_voice_i,
  input  wire  [CW-1:0]           n_m1_i,
  input  wire  [VW-1:0]           sel_i,
  input  wire  [SND_W-1:0]        snd_i,
  output logic [VW-1:0]           probe_voice_o,
  output vals_pkg::probe_t        probe_o
);

  logic [VW-1:0]    order_q [MAX_VOICES];
  logic [VW-1:0]    order_d [MAX_VOICES];
  logic [SND_W-1:0] sound_q [MAX_VOICES];
  logic [MAX_VOICES-1:0] valid_q, playing_q;
  logic [VW-1:0]    chosen;

  // Probe the voice at the selected position
  assign chosen            = order_q[sel_i];
  assign probe_voice_o     = chosen;
  assign probe_o.playing   = playing_q[chosen];
  assign probe_o.match     = valid_q[chosen] && (sound_q[chosen] == snd_i);

  always_comb begin
    for (int v = 0; v < MAX_VOICES; v++) begin
      order_d[v] = order_q[v];
    end
    if (cmd_i.identity) begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        order_d[v] = VW'(v);
      end
    end else if (cmd_i.commit) begin
      // Close the gap behind the selected position, then append it
      for (int v = 0; v < MAX_VOICES - 1; v++) begin
        if ((VW'(v) >= sel_i) && (CW'(v) < n_m1_i)) begin
          order_d[v] = order_q[v + 1];
        end
      end
      for (int v = 0; v < MAX_VOICES; v++) begin
        if (CW'(v) == n_m1_i) begin
          order_d[v] = chosen;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        order_q[v] <= VW'(v);
      end
      valid_q   <= '0;
      playing_q <= '0;
    end else begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        order_q[v] <= order_d[v];
      end
      if (cmd_i.stop_all) begin
        playing_q <= '0;
      end else if (cmd_i.finish) begin
        playing_q[fin_voice_i] <= 1'b0;
      end else if (cmd_i.commit) begin
        playing_q[chosen] <= 1'b1;
      end
      if (cmd_i.commit) begin
        valid_q[chosen] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      sound_q[chosen] <= snd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/voice_allocator_lru_steal.sv
// Top level of the voice allocator with least-recently-used stealing.
`default_nettype none

// Channel   | Direction | Contents
// s_axis    | in        | tuser: action; tdata: sound_id, volume, pitch, finished_voice
// m_axis    | out       | tdata: voice, switch_sound, volume_pct, pitch_pct
// cfg       | in        | data: sources_in_use (write also restores identity order)
//
// A play request walks the priority positions of the n voices in use: the shared
// probe visits one priority position a cycle, first looking for an idle voice, then,
// if none is idle, for a voice holding the same sound, and then commits.
// Finished and stop transactions complete in their accept cycle.
// Reset restores six voices in use, identity order, nothing attached or playing.
// A stalled result holds the commit until the output register frees.
module voice_allocator_lru_steal #(
  parameter int unsigned MAX_VOICES    = 8,
  parameter int unsigned SOUND_ID_BITS = 10
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] sound_id, [25:10] volume, [41:26] pitch, [44:42] finished_voice, rest zero
  input  wire  [47:0] s_axis_tdata_i,
  // [1:0] action
  input  wire  [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [2:0] voice, [3] switch_sound, [10:4] volume_pct, [18:11] pitch_pct, rest zero
  output logic [23:0] m_axis_tdata_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_data_i
);

  localparam int unsigned VW    = $clog2(MAX_VOICES);
  localparam int unsigned CW    = $clog2(MAX_VOICES + 1);
  localparam int unsigned SND_W = (SOUND_ID_BITS < vals_pkg::SOUND_W) ?
                                  SOUND_ID_BITS : vals_pkg::SOUND_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FREE   = 2'd1;  // look for a voice that is not playing
  localparam logic [1:0] ST_SAME   = 2'd2;  // look for the last voice holding the sound
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  src_q;
  logic [VW-1:0] pos_q, pos_d, sel_q, sel_d;
  logic [SND_W-1:0] snd_q;
  logic [vals_pkg::VOL_W-1:0]   vol_q;
  logic [vals_pkg::PITCH_W-1:0] pitch_q;
  logic        out_valid_q;
  logic [23:0] out_data_q;

  logic [31:0] n32;
  logic [CW-1:0] n_m1;
  logic        last_pos, out_free, in_acc, cfg_acc;
  logic [VW-1:0] probe_idx, probe_voice;
  vals_pkg::probe_t     probe;
  vals_pkg::store_cmd_t cmd;

  logic signed [15:0] vol_in, pitch_in;
  logic [vals_pkg::VOL_W-1:0]   vol_clamped;
  logic [vals_pkg::PITCH_W-1:0] pitch_clamped;
  logic [2:0]  fin_in;
  logic        fin_ok;

  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Voices in use: a count of zero acts as one, oversize acts as the maximum
  always_comb begin
    n32 = 32'(src_q);
    if (n32 == 32'd0) begin
      n32 = 32'd1;
    end else if (n32 > 32'(MAX_VOICES)) begin
      n32 = 32'(MAX_VOICES);
    end
  end
  assign n_m1     = CW'(n32 - 32'd1);
  assign last_pos = (CW'(pos_q) == n_m1);

  // Clamp the levels on entry
  assign vol_in   = s_axis_tdata_i[25:10];
  assign pitch_in = s_axis_tdata_i[41:26];
  always_comb begin
    if (vol_in < vals_pkg::VOL_MIN) begin
      vol_clamped = '0;
    end else if (vol_in > vals_pkg::VOL_MAX) begin
      vol_clamped = vals_pkg::VOL_MAX[vals_pkg::VOL_W-1:0];
    end else begin
      vol_clamped = vol_in[vals_pkg::VOL_W-1:0];
    end
    if (pitch_in < vals_pkg::PITCH_MIN) begin
      pitch_clamped = vals_pkg::PITCH_MIN[vals_pkg::PITCH_W-1:0];
    end else if (pitch_in > vals_pkg::PITCH_MAX) begin
      pitch_clamped = vals_pkg::PITCH_MAX[vals_pkg::PITCH_W-1:0];
    end else begin
      pitch_clamped = pitch_in[vals_pkg::PITCH_W-1:0];
    end
  end

  // Ignore a finished voice beyond the last voice
  assign fin_in = s_axis_tdata_i[44:42];
  assign fin_ok = (32'(fin_in) < 32'(MAX_VOICES));

  assign probe_idx = (state_q == ST_COMMIT) ? sel_q : pos_q;

  // Sequencer: walk the priority order one position a cycle
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    sel_d        = sel_q;
    cmd          = '0;
    cmd.identity = cfg_acc;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser_i)
            vals_pkg::ACT_PLAY: begin
              state_d = ST_FREE;
              pos_d   = '0;
            end
            vals_pkg::ACT_FINISH: begin
              cmd.finish = fin_ok;
            end
            vals_pkg::ACT_STOP: begin
              cmd.stop_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FREE: begin
        if (!probe.playing) begin
          sel_d   = pos_q;
          state_d = ST_COMMIT;
        end else if (last_pos) begin
          // Every voice busy: fall back to the head unless a sound match turns up
          sel_d   = '0;
          pos_d   = '0;
          state_d = ST_SAME;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_SAME: begin
        if (probe.match) begin
          sel_d = pos_q;
        end
        if (last_pos) begin
          state_d = ST_COMMIT;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= vals_pkg::COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        src_q <= cfg_data_i;
      end
      if (cmd.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    sel_q <= sel_d;
    if (in_acc) begin
      snd_q   <= SND_W'(s_axis_tdata_i[9:0]);
      vol_q   <= vol_clamped;
      pitch_q <= pitch_clamped;
    end
    if (cmd.commit) begin
      out_data_q <= {5'd0, pitch_q, vol_q, !probe.match, 3'(probe_voice)};
    end
  end

  vals_store #(
    .MAX_VOICES (MAX_VOICES),
    .SND_W      (SND_W),
    .VW         (VW),
    .CW         (CW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .fin_voice_i   (VW'(fin_in)),
    .n_m1_i        (n_m1),
    .sel_i         (probe_idx),
    .snd_i         (snd_q),
    .probe_voice_o (probe_voice),
    .probe_o       (probe)
  );

endmodule

`default_nettype wire
